### rtl/gated_moving_average_filter_assert.svh
// Assertion macros used by the top level of the gated moving-average filter.
`ifndef GATED_MOVING_AVERAGE_FILTER_ASSERT_SVH
`define GATED_MOVING_AVERAGE_FILTER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define GMAF_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gmaf assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define GMAF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gmaf assertion failed");

`else

`define GMAF_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define GMAF_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

### rtl/gmaf_pkg.sv
// Shared types and constants of the gated moving-average filter.
package gmaf_pkg;

    localparam int MAX_WINDOW_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int SAMPLE_W   = 16;
    localparam int AVG_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int WL_W       = 6;
    localparam int BAND_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_BAND   = 1'd1;

    localparam logic [WL_W-1:0]   WINDOW_LENGTH_RST = 6'd5;
    localparam logic [BAND_W-1:0] ACCEPT_BAND_RST   = 16'd150;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_PRIMED   = 2'd0;
    localparam status_t ST_ACCEPTED = 2'd1;
    localparam status_t ST_REJECTED = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;        // capture the sample, clear index and sum
        logic    idx_inc;     // advance the slot index
        logic    prime_wr;    // write the sample into the indexed slot
        logic    rd_newest;   // read the newest slot
        logic    shift_rd;    // read the slot above the index for the shift
        logic    new_wr;      // store the sample as newest and add it to the sum
        logic    div_start;   // start the sum / length division
        logic    out_load;    // load the result register
        status_t out_status;  // status of the result being loaded
    } gmaf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic primed;
        logic idx_last;
        logic shift_last;
        logic single;
        logic in_band;
        logic div_done;
        logic out_full;
    } gmaf_sts_t;

endpackage

### rtl/gmaf_div.sv
// Restoring divider that yields one quotient bit per cycle.
module gmaf_div #(
    parameter int DIVIDEND_W = 21,
    parameter int DIVISOR_W  = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;

    always_comb begin
        shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = shifted - {1'b0, divisor};
        rem_next = rem_reg;
        quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
        if (shifted >= {1'b0, divisor}) begin
            rem_next    = diff[DIVISOR_W-1:0];
            quo_next[0] = 1'b1;
        end else begin
            rem_next = shifted[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/gmaf_dp.sv
// Datapath: configuration, window memory, running sum, divider and result register.
module gmaf_dp #(
    parameter int MAX_WINDOW  = gmaf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = gmaf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [gmaf_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [gmaf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [gmaf_pkg::SAMPLE_W-1:0]       s_sample,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [gmaf_pkg::AVG_W-1:0]          m_average,
    output gmaf_pkg::status_t                   m_status,
    input  gmaf_pkg::gmaf_cmd_t                 cmd,
    output gmaf_pkg::gmaf_sts_t                 sts
);

    localparam int ADDR_W = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int CMP_W  = gmaf_pkg::BAND_W + 1;

    logic [gmaf_pkg::WL_W-1:0]   window_length_reg;
    logic [gmaf_pkg::BAND_W-1:0] accept_band_reg;

    logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [ADDR_W-1:0]      idx_reg;
    logic [ADDR_W-1:0]      mv_idx_reg;
    logic                   mv_valid_reg;
    logic [SUM_W-1:0]       acc_reg;
    logic [SAMPLE_BITS-1:0] last_avg_reg;
    logic                   primed_reg;
    logic                   m_valid_reg;
    logic [SAMPLE_BITS-1:0] m_average_reg;
    gmaf_pkg::status_t      m_status_reg;

    logic [LEN_W-1:0]       len;
    logic [ADDR_W-1:0]      last_idx;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [SAMPLE_BITS-1:0] wr_data;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   div_done;
    logic [SUM_W-1:0]       quotient;
    logic [CMP_W-1:0]       s_ext;
    logic [CMP_W-1:0]       n_ext;
    logic [CMP_W-1:0]       d_ext;
    logic                   upper_ok;
    logic                   near_ok;
    logic                   low_ok;

    // Active length: zero counts as one, anything above the depth saturates.
    always_comb begin
        if (window_length_reg == '0) begin
            len = LEN_W'(1);
        end else if ({1'b0, window_length_reg} > 7'(MAX_WINDOW)) begin
            len = LEN_W'(MAX_WINDOW);
        end else begin
            len = LEN_W'(window_length_reg);
        end
    end

    assign last_idx = ADDR_W'(len - 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= gmaf_pkg::WINDOW_LENGTH_RST;
            accept_band_reg   <= gmaf_pkg::ACCEPT_BAND_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                gmaf_pkg::CFG_WINDOW_LENGTH: begin
                    window_length_reg <= cfg_wdata[gmaf_pkg::WL_W-1:0];
                end
                gmaf_pkg::CFG_ACCEPT_BAND: begin
                    accept_band_reg <= cfg_wdata[gmaf_pkg::BAND_W-1:0];
                end
            endcase
        end
    end

    // Band test against the newest stored sample, done on unsigned values wide enough
    // that no sum wraps, with the band added to the sample so no bound goes negative.
    always_comb begin
        s_ext    = CMP_W'(sample_reg);
        n_ext    = CMP_W'(rd_data_reg);
        d_ext    = CMP_W'(accept_band_reg);
        upper_ok = s_ext < (n_ext + d_ext);
        near_ok  = (s_ext >= d_ext) && ((s_ext + d_ext) > n_ext);
        low_ok   = (s_ext <= d_ext) && (s_ext != '0);
    end

    // One write port: priming fill, shift move or newest write, never together.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = sample_reg;
        priority if (cmd.prime_wr) begin
            wr_en = 1'b1;
        end else if (cmd.new_wr) begin
            wr_en   = 1'b1;
            wr_addr = last_idx;
        end else if (mv_valid_reg) begin
            wr_en   = 1'b1;
            wr_addr = mv_idx_reg;
            wr_data = rd_data_reg;
        end
    end

    assign rd_en   = cmd.rd_newest | cmd.shift_rd;
    assign rd_addr = cmd.rd_newest ? last_idx : ADDR_W'(idx_reg + 1'b1);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_valid_reg <= 1'b0;
        end else begin
            mv_valid_reg <= cmd.shift_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= s_sample[SAMPLE_BITS-1:0];
            idx_reg    <= '0;
            acc_reg    <= '0;
        end else begin
            if (cmd.idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.shift_rd) begin
                mv_idx_reg <= idx_reg;
            end
            if (cmd.new_wr) begin
                acc_reg <= acc_reg + SUM_W'(sample_reg);
            end else if (mv_valid_reg) begin
                acc_reg <= acc_reg + SUM_W'(rd_data_reg);
            end
        end
    end

    gmaf_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (LEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (acc_reg),
        .divisor  (len),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg   <= 1'b0;
            last_avg_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
                unique case (cmd.out_status)
                    gmaf_pkg::ST_PRIMED: begin
                        primed_reg   <= 1'b1;
                        last_avg_reg <= sample_reg;
                    end
                    gmaf_pkg::ST_ACCEPTED: begin
                        last_avg_reg <= quotient[SAMPLE_BITS-1:0];
                    end
                    default: begin
                        primed_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= cmd.out_status;
            unique case (cmd.out_status)
                gmaf_pkg::ST_PRIMED:   m_average_reg <= sample_reg;
                gmaf_pkg::ST_ACCEPTED: m_average_reg <= quotient[SAMPLE_BITS-1:0];
                default:               m_average_reg <= last_avg_reg;
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_average = gmaf_pkg::AVG_W'(m_average_reg);
    assign m_status  = m_status_reg;

    always_comb begin
        sts            = '0;
        sts.primed     = primed_reg;
        sts.idx_last   = idx_reg == last_idx;
        sts.shift_last = idx_reg == ADDR_W'(last_idx - 1'b1);
        sts.single     = len == LEN_W'(1);
        sts.in_band    = upper_ok && (near_ok || low_ok);
        sts.div_done   = div_done;
        sts.out_full   = m_valid_reg && !m_ready;
    end

endmodule

### rtl/gmaf_ctrl.sv
// Controller state machine that sequences priming, shifting, summing and division.
module gmaf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gmaf_pkg::gmaf_sts_t sts,
    output gmaf_pkg::gmaf_cmd_t cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_PRIME     = 4'd1;
    localparam logic [3:0] S_NEWEST_RD = 4'd2;
    localparam logic [3:0] S_CHECK     = 4'd3;
    localparam logic [3:0] S_SHIFT     = 4'd4;
    localparam logic [3:0] S_DRAIN     = 4'd5;
    localparam logic [3:0] S_NEW_WR    = 4'd6;
    localparam logic [3:0] S_DIV_GO    = 4'd7;
    localparam logic [3:0] S_DIV_WAIT  = 4'd8;
    localparam logic [3:0] S_FINISH    = 4'd9;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    gmaf_pkg::status_t res_reg;
    gmaf_pkg::status_t res_next;

    always_comb begin
        state_next     = state_reg;
        res_next       = res_reg;
        cmd            = '0;
        cmd.out_status = res_reg;
        s_ready        = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.primed ? S_NEWEST_RD : S_PRIME;
                end
            end
            S_PRIME: begin
                cmd.prime_wr = 1'b1;
                cmd.idx_inc  = 1'b1;
                if (sts.idx_last) begin
                    res_next   = gmaf_pkg::ST_PRIMED;
                    state_next = S_FINISH;
                end
            end
            S_NEWEST_RD: begin
                cmd.rd_newest = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK: begin
                if (!sts.in_band) begin
                    res_next   = gmaf_pkg::ST_REJECTED;
                    state_next = S_FINISH;
                end else if (sts.single) begin
                    state_next = S_NEW_WR;
                end else begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                cmd.shift_rd = 1'b1;
                cmd.idx_inc  = 1'b1;
                if (sts.shift_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_NEW_WR;
            end
            S_NEW_WR: begin
                cmd.new_wr = 1'b1;
                state_next = S_DIV_GO;
            end
            S_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (sts.div_done) begin
                    res_next   = gmaf_pkg::ST_ACCEPTED;
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!sts.out_full) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            res_reg   <= gmaf_pkg::ST_PRIMED;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

endmodule

### rtl/gated_moving_average_filter.sv
// Top level of the gated moving-average filter: controller, datapath and checks.
// One transaction at a time; n is the active window length, SUM_W the sum width.
// Priming writes the sample into each of the n slots; a rejection reads the newest slot
// and tests the band; an acceptance also walks the window through the one write port,
// writes the newest slot and divides the SUM_W-bit sum by n, one quotient bit per cycle.
// The next input can be taken from the cycle after the result is loaded, not earlier.
// A result still held by the receiver delays only the final load.
// Synchronous active-low reset leaves the block unprimed with last average 0, length 5
// and band 150; there is no clearing pass.
module gated_moving_average_filter #(
    parameter int MAX_WINDOW  = gmaf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = gmaf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [gmaf_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [gmaf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [gmaf_pkg::SAMPLE_W-1:0]   s_sample,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gmaf_pkg::AVG_W-1:0]      m_average,
    output gmaf_pkg::status_t               m_status
);

`include "gated_moving_average_filter_assert.svh"

    // The controller only issues commands and reads status flags; everything
    // that holds data (configuration, the window memory, the running sum, the
    // divider and the result register) lives in the datapath.
    gmaf_pkg::gmaf_cmd_t cmd;
    gmaf_pkg::gmaf_sts_t sts;
    logic                result_rejected;

    // The controller walks one transaction through its phases. On an
    // unprimed block it fills every active slot with the sample. On a primed
    // block it reads the newest slot, tests the band, and on acceptance moves
    // each slot down by one while summing the moved values, then writes the
    // sample as newest and divides the sum by the length.
    gmaf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The result register decouples the output: a finished transaction waits
    // there while the next sample is already being taken and processed; only
    // the final load waits for the register to drain.
    gmaf_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_sample  (s_sample),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_average (m_average),
        .m_status  (m_status),
        .cmd       (cmd),
        .sts       (sts)
    );

    assign result_rejected = m_status == gmaf_pkg::ST_REJECTED;

    // Only one transaction is in flight, so the input closes right after one
    // is taken.
    `GMAF_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

    // A pending result and the primed flag were written together: only a
    // rejection leaves the block unprimed.
    `GMAF_ASSERT_IMPLIES(a_primed_matches_result, aclk, aresetn, m_valid, sts.primed == !result_rejected)

    // The result register is never loaded over a result that is still held.
    `GMAF_ASSERT_IMPLIES(a_no_overwrite, aclk, aresetn, cmd.out_load, !(m_valid && !m_ready))

endmodule

### tb/gmaf_result_checker.sv
// Result checker for the gated moving-average filter: predicts each result and compares it.
module gmaf_result_checker
    import gmaf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [SAMPLE_W-1:0]   s_sample,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [AVG_W-1:0]      m_average,
    input  status_t               m_status,
    output int                    failures,
    output int                    results_seen,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = MAX_WINDOW_DEF;

    typedef struct packed {
        logic [AVG_W-1:0] average;
        status_t          status;
    } filter_out_t;

    logic [SAMPLE_W-1:0] window_q [SLOTS];
    bit                  is_primed;
    logic [AVG_W-1:0]    last_avg;
    logic [WL_W-1:0]     length_reg;
    logic [BAND_W-1:0]   band_reg;
    filter_out_t         expected_outputs [$];
    int                  mismatch_total = 0;
    int                  result_count = 0;

    // Signed acceptance test on full-width integers, so newest + band cannot wrap.
    function automatic bit sample_in_band(input int smp, input int newest, input int band);
        bit upper;
        upper = smp < newest + band;
        return (upper && smp >= band && smp > newest - band) ||
               (upper && smp <= band && smp > 0);
    endfunction

    function automatic filter_out_t predict_filter_output(input logic [SAMPLE_W-1:0] smp);
        int          n;
        int          sum;
        int          i;
        filter_out_t res;
        n = (length_reg == 0) ? 1 : ((length_reg > SLOTS) ? SLOTS : int'(length_reg));
        if (!is_primed) begin
            for (i = 0; i < n; i++)
                window_q[i] = smp;
            is_primed  = 1'b1;
            last_avg   = smp;
            res.status = ST_PRIMED;
        end else if (sample_in_band(int'(smp), int'(window_q[n-1]), int'(band_reg))) begin
            for (i = 0; i + 1 < n; i++)
                window_q[i] = window_q[i+1];
            window_q[n-1] = smp;
            sum = 0;
            for (i = 0; i < n; i++)
                sum += int'(window_q[i]);
            last_avg   = AVG_W'(sum / n);
            res.status = ST_ACCEPTED;
        end else begin
            is_primed  = 1'b0;
            res.status = ST_REJECTED;
        end
        res.average = last_avg;
        return res;
    endfunction

    always @(posedge aclk) begin
        filter_out_t got;
        filter_out_t want;
        if (!aresetn) begin
            foreach (window_q[k])
                window_q[k] = '0;
            is_primed  = 1'b0;
            last_avg   = '0;
            length_reg = WINDOW_LENGTH_RST;
            band_reg   = ACCEPT_BAND_RST;
            expected_outputs.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_WINDOW_LENGTH: length_reg = cfg_wdata[WL_W-1:0];
                    CFG_ACCEPT_BAND:   band_reg   = cfg_wdata[BAND_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_outputs.push_back(predict_filter_output(s_sample));
            if (m_valid && m_ready) begin
                got.average = m_average;
                got.status  = m_status;
                if (expected_outputs.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual average %0d status %0d",
                             $time, got.average, got.status);
                    mismatch_total++;
                end else begin
                    want = expected_outputs.pop_front();
                    if (got.average !== want.average) begin
                        $display("%0t: average mismatch, expected %0d actual %0d",
                                 $time, want.average, got.average);
                        mismatch_total++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, got.status);
                        mismatch_total++;
                    end
                end
                result_count++;
            end
        end
        failures     <= mismatch_total;
        results_seen <= result_count;
        pending      <= expected_outputs.size();
    end

endmodule

### tb/tb_gated_moving_average_filter.sv
// Testbench top for the gated moving-average filter: stimulus, configuration and verdict.
module tb_gated_moving_average_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import gmaf_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
    localparam int PHASES      = 15;
    localparam int PHASE_ITEMS = 40;
    // The last phases run with both sides fully open.
    localparam int CALM_PHASE  = 12;
    // Longest transaction is an accepted sample at 32 slots.
    localparam int TAIL_CYCLES = 100;

    // Every input of the block starts at a known value.
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic [SAMPLE_W-1:0]   s_sample  = '0;
    logic                  m_ready   = 1'b0;

    logic                  s_ready;
    logic                  m_valid;
    logic [AVG_W-1:0]      m_average;
    status_t               m_status;

    int                    failures;
    int                    results_seen;
    int                    pending;

    // Number of input transactions the block has taken so far.
    int                    sent = 0;
    // While the filter is primed and the length has not changed, its newest stored
    // sample is always the last sample sent: a primed or accepted sample becomes the
    // newest entry, and after a rejection the next sample primes the window anyway.
    logic [SAMPLE_W-1:0]   last_sample = '0;
    // Idling knobs, in percent per transaction or per cycle.
    bit                    calm = 1'b0;
    int                    gap_pct = 0;
    int                    stall_pct = 0;

    always #HALF_PERIOD aclk = ~aclk;

    gated_moving_average_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_average (m_average),
        .m_status  (m_status)
    );

    gmaf_result_checker result_chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_average    (m_average),
        .m_status     (m_status),
        .failures     (failures),
        .results_seen (results_seen),
        .pending      (pending)
    );

    // Offers one sample and holds it until the block takes it. Valid stays high
    // on return unless an idle gap follows, so back-to-back samples never lower
    // and raise valid in the same time step.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        s_valid  <= 1'b1;
        s_sample <= value;
        do @(posedge aclk); while (!s_ready);
        sent++;
        last_sample = value;
        gap = 0;
        if (!calm && $urandom_range(99) < gap_pct)
            gap = $urandom_range(1, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drops valid and waits until every result has come back, so the block is
    // idle and safe to reconfigure. Each sample yields exactly one result.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (results_seen != sent)
            @(posedge aclk);
    endtask

    // Writes the length register and then the band register. Callers always put a
    // drain or a sample between two calls, so write enable is lowered once.
    task automatic configure(input logic [CFG_DATA_W-1:0] length_word,
                             input logic [CFG_DATA_W-1:0] band_word);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_WINDOW_LENGTH;
        cfg_wdata <= length_word;
        @(posedge aclk);
        cfg_addr  <= CFG_ACCEPT_BAND;
        cfg_wdata <= band_word;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Half of the samples are a random walk inside the band around the newest sample,
    // so long runs of accepted samples build up. The rest probe the band edges,
    // the low region near zero, and plain noise that mostly gets rejected.
    function automatic logic [SAMPLE_W-1:0] next_sample(input int band);
        int level;
        int v;
        level = int'(last_sample);
        case ($urandom_range(9))
            0: v = $urandom_range(SAMPLE_MAX);
            1: v = level + band;
            2: v = level - band;
            3: v = $urandom_range(1) ? level + band - 1 : level - band + 1;
            4: v = $urandom_range(band);
            default: begin
                if (band <= 1)
                    v = level;
                else
                    v = level + int'($urandom_range(2 * band - 2)) - (band - 1);
            end
        endcase
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return SAMPLE_W'(v);
    endfunction

    // The receiver stalls in random bursts, none once calm.
    initial begin
        forever begin
            @(posedge aclk);
            if (!calm && aresetn && $urandom_range(99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] length_word;
        logic [CFG_DATA_W-1:0] band_word;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, starting from the reset values of five slots and a
        // band of 150. Prime, two accepted samples, then a sample exactly on
        // the upper band edge, which must be rejected.
        gap_pct   = 20;
        stall_pct = 20;
        send_sample(16'd1000);
        send_sample(16'd1100);
        send_sample(16'd1149);
        send_sample(16'd1299);

        // A zero band rejects everything. Priming at 32 slots also writes the
        // whole window once, so any later length change reads written slots.
        drain_results();
        configure(16'd32, 16'd0);
        send_sample(16'd0);
        send_sample(16'd0);

        // Widest band: full-scale samples pass, zero never does, and a sample
        // below the band takes the low path.
        drain_results();
        configure(16'd32, 16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'd0);
        send_sample(16'd5);
        send_sample(16'hFFFF);
        send_sample(16'd1);

        // A single slot is both oldest and newest; an accepted sample replaces it.
        drain_results();
        configure(16'd1, 16'd500);
        send_sample(16'd2000);
        send_sample(16'd2400);
        send_sample(16'd2900);

        // Length zero behaves as one. Below the band, at the band, and at the
        // upper edge of the band.
        drain_results();
        configure(16'd0, 16'd100);
        send_sample(16'd50);
        send_sample(16'd30);
        send_sample(16'd100);
        send_sample(16'd200);

        // Upper bits of the length word are ignored, leaving three slots; the
        // last sample sits exactly on the lower band edge.
        drain_results();
        configure(16'hFFC3, 16'd2);
        send_sample(16'd7);
        send_sample(16'd8);
        send_sample(16'd6);

        // A length above the window size saturates to the full window.
        drain_results();
        configure(16'd63, 16'hFFFF);
        send_sample(16'd40000);
        send_sample(16'd12345);
        send_sample(16'hFFFF);

        // Random part: each phase picks a fresh setting, then streams samples.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case ($urandom_range(7))
                0: length_word = 16'd1;
                1: length_word = 16'd32;
                2: length_word = 16'(33 + $urandom_range(30));
                3: length_word = 16'd0;
                4: length_word = {10'($urandom), 6'($urandom_range(1, 32))};
                default: length_word = 16'($urandom_range(2, 31));
            endcase
            case ($urandom_range(5))
                0: band_word = 16'd0;
                1: band_word = 16'hFFFF;
                2: band_word = 16'($urandom_range(1, 64));
                3: band_word = 16'($urandom_range(SAMPLE_MAX));
                default: band_word = 16'($urandom_range(65, 2000));
            endcase
            configure(length_word, band_word);
            calm      = (phase >= CALM_PHASE);
            gap_pct   = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 40);
            stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 40);
            repeat (PHASE_ITEMS)
                send_sample(next_sample(int'(band_word)));
        end

        drain_results();
        // Let any stray result show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (failures == 0 && pending == 0) begin
            $display("tb_gated_moving_average_filter: PASS");
        end else begin
            $display("tb_gated_moving_average_filter: FAIL");
        end
        $finish;
    end

    // A correct run needs well under a millisecond; this is many times that.
    initial begin
        #5ms;
        $display("tb_gated_moving_average_filter: FAIL");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/gmaf_pkg.sv
rtl/gmaf_div.sv
rtl/gmaf_dp.sv
rtl/gmaf_ctrl.sv
rtl/gated_moving_average_filter.sv
tb/gmaf_result_checker.sv
tb/tb_gated_moving_average_filter.sv
